>>> design/ial_pkg.sv
// shared types and constants for the indexed array list engine
// no dependencies; used by every module of the block
`default_nettype none

package ial_pkg;

    localparam int DEPTH_DEF   = 64;

    localparam int CMD_W       = 3;
    localparam int POS_W       = 6;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_DUMP   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_DEL_GONE,
        S_DEL_CHK,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_LOAD,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> design/ial_store.sv
// entry store: one write port, one read port with registered read data
// depends on ial_pkg for the word width
`default_nettype none

module ial_store #(
    parameter int DEPTH = ial_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [ial_pkg::WORD_W-1:0]  wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [ial_pkg::WORD_W-1:0]  rdata
);
    import ial_pkg::*;

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/indexed_array_list_engine_top.sv
// top level of the indexed array list engine: command sequencer, count and output register
// depends on ial_pkg and ial_store
// sequence: append and insert at the end run exec, place, emit; edit, clear and refused
// commands run exec, emit; insert first shifts the tail up by read and write steps; delete
// keeps the removed word and shifts the tail down; dump reads, then loads each item; stalls wait
// commands: one at a time; the next is taken once the sequencer is back in idle
// reset: rst_n asynchronous active low empties the list and drops the output valid
`default_nettype none

module indexed_array_list_engine_top #(
    parameter int DEPTH = ial_pkg::DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // command [2:0], position [8:3], value [40:9], zero fill [47:41]
    input  wire logic [ial_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // status [1:0], word [33:2], where [39:34], count_after [46:40], zero fill [47]
    output logic      [ial_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import ial_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                   state_reg, state_next;
    cmd_e_t                   cmd_reg, cmd_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [WORD_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    status_t                  res_status_reg, res_status_next;
    logic signed [WORD_W-1:0] res_word_reg, res_word_next;
    logic [POS_W-1:0]         res_where_reg, res_where_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic signed [WORD_W-1:0] out_word_reg, out_word_next;
    logic [POS_W-1:0]         out_where_reg, out_where_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;
    logic                     out_last_reg, out_last_next;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [WORD_W-1:0]        mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic [WORD_W-1:0]        mem_rdata;

    logic [COUNT_W-1:0]       count_ext;
    logic [COUNT_W-1:0]       pos_ext;
    logic [CNT_W-1:0]         idx_inc;
    logic [CNT_W-1:0]         idx_dec;
    logic                     is_full;
    logic                     is_empty;
    logic                     out_free;

    assign count_ext = COUNT_W'(count_reg);
    assign pos_ext   = COUNT_W'(pos_reg);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign is_full   = (count_ext == COUNT_W'(DEPTH));
    assign is_empty  = (count_ext == '0);
    assign out_free  = !out_valid_reg || m_axis_tready;

    ial_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        res_where_reg  <= res_where_next;
        out_status_reg <= out_status_next;
        out_word_reg   <= out_word_next;
        out_where_reg  <= out_where_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        res_where_next  = res_where_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_where_next  = out_where_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        s_axis_tready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd_next   = cmd_e_t'(s_axis_tdata[CMD_W-1:0]);
                    pos_next   = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
                    val_next   = s_axis_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_word_next   = val_reg;
                res_where_next  = pos_reg;
                unique case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                            res_where_next  = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            pos_next   = count_ext[POS_W-1:0];
                            state_next = S_PLACE;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else if (pos_ext > count_ext)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_EMIT;
                        end
                        else if (pos_ext == count_ext)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    CMD_EDIT:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (pos_ext >= count_ext)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg[AW-1:0];
                            mem_wdata = val_reg;
                        end
                        state_next = S_EMIT;
                    end
                    CMD_DELETE:
                    begin
                        res_word_next = '0;
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_EMIT;
                        end
                        else if (pos_ext >= count_ext)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = pos_reg[AW-1:0];
                            state_next = S_DEL_GONE;
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                            res_word_next   = '0;
                            res_where_next  = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_DUMP_RD;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next     = '0;
                        res_word_next  = '0;
                        res_where_next = '0;
                        state_next     = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // insert: move the tail up one entry at a time, from the end down
            S_SHIFT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_dec[AW-1:0];
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = mem_rdata;
                idx_next  = idx_dec;
                if (COUNT_W'(idx_dec) == pos_ext)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end

            S_PLACE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg[AW-1:0];
                mem_wdata       = val_reg;
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_OK;
                res_word_next   = val_reg;
                res_where_next  = pos_reg;
                state_next      = S_EMIT;
            end

            // delete: keep the removed word, then move the tail down
            S_DEL_GONE:
            begin
                res_word_next = mem_rdata;
                idx_next      = CNT_W'(pos_reg);
                state_next    = S_DEL_CHK;
            end

            S_DEL_CHK:
            begin
                if (COUNT_W'(idx_inc) < count_ext)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_inc[AW-1:0];
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_inc;
                state_next = S_DEL_CHK;
            end

            S_DUMP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_DUMP_LOAD;
            end

            S_DUMP_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_word_next   = mem_rdata;
                    out_where_next  = POS_W'(idx_reg);
                    out_count_next  = count_ext;
                    out_last_next   = (COUNT_W'(idx_inc) == count_ext);
                    idx_next        = idx_inc;
                    if (COUNT_W'(idx_inc) == count_ext)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DUMP_RD;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_word_next   = res_word_reg;
                    out_where_next  = res_where_reg;
                    out_count_next  = count_ext;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_where_reg, out_word_reg, out_status_reg};

endmodule

`default_nettype wire

>>> design/ial_checker.sv
// port-level checks for the indexed array list engine, bound to the top level
// depends on ial_pkg and indexed_array_list_engine_top
`default_nettype none

module ial_checker #(
    parameter int DEPTH = ial_pkg::DEPTH_DEF
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [ial_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                             m_axis_tlast
);
    import ial_pkg::*;

    logic [STATUS_W-1:0] out_status;
    logic [COUNT_W-1:0]  out_count;

    assign out_status = m_axis_tdata[STATUS_W-1:0];
    assign out_count  = m_axis_tdata[STATUS_W+WORD_W+POS_W+COUNT_W-1:STATUS_W+WORD_W+POS_W];

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in back-to-back cycles");

    // the count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_count <= COUNT_W'(DEPTH))
        else $error("count_after beyond capacity");

    // an error always ends the command
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_status != ST_OK) |-> m_axis_tlast)
        else $error("error item without last");

    // an empty status always reports a count of zero
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_status == ST_EMPTY) |-> out_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind indexed_array_list_engine_top ial_checker #(.DEPTH(DEPTH)) u_ial_checker (.*);

`default_nettype wire
